// File: rtl/binomial_mod_factorial_table_top_assert.svh
// assertion macros for the binomial table block
`ifndef BINOMIAL_MOD_FACTORIAL_TABLE_TOP_ASSERT_SVH
`define BINOMIAL_MOD_FACTORIAL_TABLE_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BMFT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bmft check failed");

// antecedent implies consequent in the next cycle
`define BMFT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bmft check failed");

`endif

// File: rtl/bmft_pkg.sv
// shared constants for the binomial table block
package bmft_pkg;
	localparam int MAX_N_DEF = 4096;
	localparam int MOD_W = 31;
	localparam int DVD_W = 62;
	localparam int TSZ_W = 13;

	localparam logic [1:0] REQ_BUILD = 2'd0;
	localparam logic [1:0] REQ_BINOM = 2'd1;
	localparam logic [1:0] REQ_MULTI = 2'd2;
	localparam logic [1:0] REQ_IGNORED = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_NOT_BUILT = 2'd2;

	localparam logic CFG_MODULUS = 1'b0;
	localparam logic CFG_TABLE_SIZE = 1'b1;

	localparam logic [MOD_W-1:0] MODULUS_RST = 31'd1000000007;
	localparam logic [TSZ_W-1:0] TABLE_SIZE_RST = 13'd4096;
endpackage

// File: rtl/bmft_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module bmft_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [bmft_pkg::DVD_W-1:0] dividend,
	input  logic [bmft_pkg::MOD_W-1:0] divisor,
	output logic done,
	output logic [bmft_pkg::DVD_W-1:0] quot,
	output logic [bmft_pkg::MOD_W-1:0] rem
);
	localparam int CNT_W = $clog2(bmft_pkg::DVD_W);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [bmft_pkg::DVD_W-1:0] dvd_q;
	logic [bmft_pkg::MOD_W-1:0] dvs_q;
	logic [bmft_pkg::MOD_W-1:0] rem_q;
	logic [bmft_pkg::MOD_W:0] rem_sh;
	logic [bmft_pkg::MOD_W:0] rem_sub;
	logic ge;

	assign rem_sh = {rem_q, dvd_q[bmft_pkg::DVD_W-1]};
	assign ge = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(bmft_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[bmft_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? rem_sub[bmft_pkg::MOD_W-1:0] : rem_sh[bmft_pkg::MOD_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem = rem_q;
endmodule

// File: rtl/binomial_mod_factorial_table_top.sv
// binomial coefficient modulo a prime from factorial tables, top level
// A transaction is taken when start is high and busy is low; its single result shows on
// value/status for one cycle with done high and cannot be held off, and busy is low again in
// that cycle. Every modular reduction goes through one bit-serial divider, and the products of
// the 31x31 multiplier are reduced there. A query with k of one reduces n in the divider
// without the multiplier. Not-built, out of range, negative or k above n queries and unknown
// request types finish without the divider. Tables need no clearing pass after reset.
`include "binomial_mod_factorial_table_top_assert.svh"
module binomial_mod_factorial_table_top #(
	parameter int MAX_N = bmft_pkg::MAX_N_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] req_type,
	input  logic signed [13:0] top,
	input  logic signed [13:0] choose,
	output logic done,
	output logic [bmft_pkg::MOD_W-1:0] value,
	output logic [1:0] status,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [bmft_pkg::MOD_W-1:0] cfg_data
);
	localparam int AW = $clog2(MAX_N + 1);
	localparam int CW = $clog2(MAX_N + 2);
	localparam int MW = bmft_pkg::MOD_W;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_B_INIT0 = 5'd1;
	localparam logic [4:0] S_B_INIT1 = 5'd2;
	localparam logic [4:0] S_B_LOOP = 5'd3;
	localparam logic [4:0] S_B_QR = 5'd4;
	localparam logic [4:0] S_B_RD0 = 5'd5;
	localparam logic [4:0] S_B_M1 = 5'd6;
	localparam logic [4:0] S_B_INV = 5'd7;
	localparam logic [4:0] S_B_FACT = 5'd8;
	localparam logic [4:0] S_B_IFACT = 5'd9;
	localparam logic [4:0] S_Q_CHK = 5'd10;
	localparam logic [4:0] S_Q_K1 = 5'd11;
	localparam logic [4:0] S_Q_RD0 = 5'd12;
	localparam logic [4:0] S_Q_RD1 = 5'd13;
	localparam logic [4:0] S_Q_RD2 = 5'd14;
	localparam logic [4:0] S_Q_M2 = 5'd15;
	localparam logic [4:0] S_Q_DONE = 5'd16;
	localparam logic [4:0] S_M_MUL = 5'd17;
	localparam logic [4:0] S_M_DIV = 5'd18;
	localparam logic [4:0] S_M_WAIT = 5'd19;

	logic [4:0] state_q;
	logic [4:0] ret_q;
	logic [MW-1:0] modulus_q;
	logic [bmft_pkg::TSZ_W-1:0] table_size_q;
	logic tables_ready_q;
	logic [MW-1:0] m_q;
	logic [CW-1:0] sz_q;
	logic [CW-1:0] bsz_q;
	logic [CW-1:0] i_q;
	logic signed [15:0] n_q;
	logic signed [15:0] k_q;
	logic signed [15:0] nk;
	logic [MW-1:0] q_q;
	logic [AW-1:0] r_q;
	logic [MW-1:0] op_a_q;
	logic [MW-1:0] op_b_q;
	logic [bmft_pkg::DVD_W-1:0] mul_q;
	logic [MW-1:0] res_q;
	logic [MW-1:0] inv_i_q;
	logic [MW-1:0] fact_prev_q;
	logic [MW-1:0] ifact_prev_q;
	logic [MW-1:0] tmp_q;
	logic done_q;
	logic [MW-1:0] value_q;
	logic [1:0] status_q;

	logic [MW-1:0] fact_mem [MAX_N+1];
	logic [MW-1:0] ifact_mem [MAX_N+1];
	logic [MW-1:0] inv_mem [MAX_N+1];
	logic [MW-1:0] fact_rd_q;
	logic [MW-1:0] ifact_rd_q;
	logic [MW-1:0] inv_rd_q;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] fact_raddr;
	logic [AW-1:0] ifact_raddr;
	logic fact_we;
	logic ifact_we;
	logic inv_we;
	logic [MW-1:0] fact_wd;
	logic [MW-1:0] ifact_wd;
	logic [MW-1:0] inv_wd;

	logic div_start;
	logic [bmft_pkg::DVD_W-1:0] div_dvd;
	logic [MW-1:0] div_dvs;
	logic div_done;
	logic [bmft_pkg::DVD_W-1:0] div_quot;
	logic [MW-1:0] div_rem;

	logic [MW-1:0] one_m;
	logic [MW-1:0] m_eff;
	logic [CW-1:0] sz_eff;
	logic [MW-1:0] inv_i;
	logic n_over;

	assign m_eff = (modulus_q < MW'(2)) ? MW'(1) : modulus_q;
	assign one_m = MW'(m_q != MW'(1));
	assign nk = n_q - k_q;
	assign inv_i = (res_q == '0) ? '0 : m_q - res_q;
	assign n_over = !n_q[15] && (32'(n_q[14:0]) > 32'(bsz_q));

	always_comb begin
		if (32'(table_size_q) > 32'(MAX_N)) begin
			sz_eff = CW'(MAX_N);
		end else if (table_size_q == '0) begin
			sz_eff = CW'(1);
		end else begin
			sz_eff = CW'(table_size_q);
		end
	end

	bmft_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(div_dvs),
		.done(div_done),
		.quot(div_quot),
		.rem(div_rem)
	);

	always_comb begin
		div_start = 1'b0;
		div_dvd = mul_q;
		div_dvs = m_q;
		unique case (state_q)
			S_B_LOOP: begin
				div_start = i_q <= sz_q;
				div_dvd = bmft_pkg::DVD_W'(m_q);
				div_dvs = MW'(i_q);
			end
			S_Q_CHK: begin
				div_start = tables_ready_q && !n_over && !n_q[15] && !k_q[15]
					&& !(n_q < k_q) && (k_q == 16'sd1);
				div_dvd = bmft_pkg::DVD_W'(n_q[14:0]);
			end
			S_M_DIV: div_start = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		wr_addr = i_q[AW-1:0];
		fact_we = 1'b0;
		ifact_we = 1'b0;
		inv_we = 1'b0;
		fact_wd = res_q;
		ifact_wd = res_q;
		inv_wd = inv_i;
		fact_raddr = AW'(n_q);
		ifact_raddr = AW'(k_q);
		unique case (state_q)
			S_B_INIT0: begin
				wr_addr = '0;
				fact_we = 1'b1;
				ifact_we = 1'b1;
				inv_we = 1'b1;
				fact_wd = one_m;
				ifact_wd = one_m;
				inv_wd = '0;
			end
			S_B_INIT1: begin
				wr_addr = AW'(1);
				fact_we = 1'b1;
				ifact_we = 1'b1;
				inv_we = 1'b1;
				fact_wd = one_m;
				ifact_wd = one_m;
				inv_wd = one_m;
			end
			S_B_INV: inv_we = 1'b1;
			S_B_FACT: fact_we = 1'b1;
			S_B_IFACT: ifact_we = 1'b1;
			S_Q_RD1: ifact_raddr = AW'(nk);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fact_we) begin
			fact_mem[wr_addr] <= fact_wd;
		end
		fact_rd_q <= fact_mem[fact_raddr];
	end

	always_ff @(posedge clk) begin
		if (ifact_we) begin
			ifact_mem[wr_addr] <= ifact_wd;
		end
		ifact_rd_q <= ifact_mem[ifact_raddr];
	end

	always_ff @(posedge clk) begin
		if (inv_we) begin
			inv_mem[wr_addr] <= inv_wd;
		end
		inv_rd_q <= inv_mem[r_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= bmft_pkg::MODULUS_RST;
			table_size_q <= bmft_pkg::TABLE_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == bmft_pkg::CFG_MODULUS) begin
				modulus_q <= cfg_data;
			end else begin
				table_size_q <= cfg_data[bmft_pkg::TSZ_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			tables_ready_q <= 1'b0;
			bsz_q <= '0;
			m_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (req_type == bmft_pkg::REQ_BUILD) begin
							m_q <= m_eff;
							state_q <= S_B_INIT0;
						end else if (req_type == bmft_pkg::REQ_BINOM
							|| req_type == bmft_pkg::REQ_MULTI) begin
							state_q <= S_Q_CHK;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_B_INIT0: state_q <= S_B_INIT1;
				S_B_INIT1: state_q <= S_B_LOOP;
				S_B_LOOP: begin
					if (i_q > sz_q) begin
						tables_ready_q <= 1'b1;
						bsz_q <= sz_q;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_B_QR;
					end
				end
				S_B_QR: begin
					if (div_done) begin
						state_q <= S_B_RD0;
					end
				end
				S_B_RD0: state_q <= S_B_M1;
				S_B_M1: begin
					ret_q <= S_B_INV;
					state_q <= S_M_MUL;
				end
				S_B_INV: begin
					ret_q <= S_B_FACT;
					state_q <= S_M_MUL;
				end
				S_B_FACT: begin
					ret_q <= S_B_IFACT;
					state_q <= S_M_MUL;
				end
				S_B_IFACT: state_q <= S_B_LOOP;
				S_Q_CHK: begin
					if (!tables_ready_q || n_over || n_q[15] || k_q[15] || n_q < k_q) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (k_q == 16'sd1) begin
						state_q <= S_Q_K1;
					end else begin
						state_q <= S_Q_RD0;
					end
				end
				S_Q_K1: begin
					if (div_done) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_Q_RD0: state_q <= S_Q_RD1;
				S_Q_RD1: state_q <= S_Q_RD2;
				S_Q_RD2: begin
					ret_q <= S_Q_M2;
					state_q <= S_M_MUL;
				end
				S_Q_M2: begin
					ret_q <= S_Q_DONE;
					state_q <= S_M_MUL;
				end
				S_Q_DONE: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_M_MUL: state_q <= S_M_DIV;
				S_M_DIV: state_q <= S_M_WAIT;
				S_M_WAIT: begin
					if (div_done) begin
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q) inside
			S_IDLE: begin
				k_q <= 16'(choose);
				if (req_type == bmft_pkg::REQ_MULTI) begin
					n_q <= 16'(top) + 16'(choose) - 16'sd1;
				end else begin
					n_q <= 16'(top);
				end
				sz_q <= sz_eff;
				i_q <= CW'(2);
				fact_prev_q <= one_m;
				ifact_prev_q <= one_m;
				value_q <= '0;
				status_q <= bmft_pkg::ST_OK;
			end
			S_B_INIT0, S_B_INIT1: begin
				fact_prev_q <= one_m;
				ifact_prev_q <= one_m;
				value_q <= '0;
				status_q <= bmft_pkg::ST_OK;
			end
			S_B_QR: begin
				q_q <= div_quot[MW-1:0];
				r_q <= div_rem[AW-1:0];
			end
			S_B_M1: begin
				op_a_q <= inv_rd_q;
				op_b_q <= q_q;
			end
			S_B_INV: begin
				inv_i_q <= inv_i;
				op_a_q <= fact_prev_q;
				op_b_q <= MW'(i_q);
			end
			S_B_FACT: begin
				fact_prev_q <= res_q;
				op_a_q <= ifact_prev_q;
				op_b_q <= inv_i_q;
			end
			S_B_IFACT: begin
				ifact_prev_q <= res_q;
				i_q <= i_q + 1'b1;
			end
			S_Q_CHK: begin
				value_q <= '0;
				if (!tables_ready_q) begin
					status_q <= bmft_pkg::ST_NOT_BUILT;
				end else if (n_over) begin
					status_q <= bmft_pkg::ST_RANGE;
				end else begin
					status_q <= bmft_pkg::ST_OK;
				end
			end
			S_Q_K1: value_q <= div_rem;
			S_Q_RD1: begin
				op_a_q <= fact_rd_q;
				op_b_q <= ifact_rd_q;
			end
			S_Q_RD2: tmp_q <= ifact_rd_q;
			S_Q_M2: begin
				op_a_q <= res_q;
				op_b_q <= tmp_q;
			end
			S_Q_DONE: value_q <= res_q;
			S_M_MUL: mul_q <= op_a_q * op_b_q;
			S_M_WAIT: res_q <= div_rem;
			default: ;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign value = value_q;
	assign status = status_q;
	assign cfg_ready = 1'b1;

	`BMFT_ASSERT_NXT(a_start_busy, start && !busy, busy || done)
	`BMFT_ASSERT_IMP(a_status_zero, done && status != bmft_pkg::ST_OK, value == '0)
	`BMFT_ASSERT_IMP(a_div_idle, div_done, state_q != S_IDLE)
	`BMFT_ASSERT_NXT(a_build_ready, state_q == S_B_LOOP && i_q > sz_q, tables_ready_q && done)
endmodule
